@@ sv/pss_pkg.sv @@
package pss_pkg;

   localparam int COORD_W    = 24;               // Q16.8 coordinate
   localparam int STR_W      = 16;               // Q8.8 string length
   localparam int DIFF_W     = COORD_W + 1;      // anchor to point difference
   localparam int PROD_W     = 2 * COORD_W;      // shared multiplier product
   localparam int D2_W       = PROD_W + 1;       // dx^2 + dy^2
   localparam int RAD_W      = 64;               // radicand d2 << 14
   localparam int ROOT_W     = RAD_W / 2;        // r
   localparam int REM_W      = ROOT_W + 4;       // partial remainder
   localparam int SQRT_SHIFT = 14;
   localparam int NUM_SHIFT  = 7;                // a*s*128
   localparam int NUM_W      = 48;               // a*s*128 + r/2
   localparam int QUO_W      = 25;               // quotient bits (q <= |d| < 2^24)
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int CNT_W      = 5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_S,
      ST_CHECK,
      ST_SQRT_LD,
      ST_SQRT_RUN,
      ST_MUL_AX,
      ST_DIV_LD_X,
      ST_DIV_RUN_X,
      ST_UPD_X,
      ST_MUL_AY,
      ST_DIV_LD_Y,
      ST_DIV_RUN_Y,
      ST_UPD_Y,
      ST_DONE
   } pss_state_type;

   typedef enum logic [2:0] {
      IU_HOLD,
      IU_LOAD,
      IU_STEP_SQRT,
      IU_STEP_DIV
   } pss_iu_op_type;

   typedef struct packed {
      pss_iu_op_type     op;
      logic [REM_W-1:0]  load_rem;
      logic [RAD_W-1:0]  load_src;
      logic [ROOT_W-1:0] divisor;
   } pss_iu_ctrl_type;

endpackage

@@ sv/pull_string_stroke_smoother_top.sv @@
// Channel  | Ports                                               | Direction
// ---------+-----------------------------------------------------+----------
// request  | req_valid/req_ready, req_new_x/y, req_stroke_start  | in
// response | rsp_valid/rsp_ready, rsp_out_x/y                    | out
// csr      | csr_wr_en, csr_wr_data (strength)                   | in
//
// After accept: a stroke-start (or first) point goes to finish; others pass difference,
//   squares and check; then absorbed, moved to the point (zero strength) or pulled.
// One request is in flight at a time; req_ready is high only when idle.
// Reset (synchronous) clears the anchor, strength and response valid.
// The response register holds a result until taken; a new request may be
//   accepted meanwhile, its result waits in the finish state if needed.
module pull_string_stroke_smoother_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [23:0]  req_new_x,
   input  logic signed [23:0]  req_new_y,
   input  logic                req_stroke_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [23:0]  rsp_out_x,
   output logic signed [23:0]  rsp_out_y,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);
   import pss_pkg::*;

   pss_state_type state_ff, state_in;

   // control state
   logic                 anchor_valid_ff;
   logic                 rsp_valid_ff;
   logic [STR_W-1:0]     strength_ff;
   logic [CNT_W-1:0]     cnt_ff;

   // datapath
   logic [COORD_W-1:0]   px_ff, py_ff;
   logic [COORD_W-1:0]   ax_ff, ay_ff;
   logic [COORD_W-1:0]   adx_ff, ady_ff;   // |dx|, |dy|
   logic                 sx_ff, sy_ff;     // sign of dx, dy
   logic [PROD_W-1:0]    prod_ff;
   logic [D2_W-1:0]      d2_ff;
   logic [ROOT_W-1:0]    r_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff;

   logic                 accept;
   logic                 new_stroke;
   logic                 absorbed;
   logic                 load_rsp;
   logic [COORD_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]    prod_in;
   logic [DIFF_W-1:0]    dx, dy;
   logic [NUM_W-1:0]     num;
   logic [COORD_W-1:0]   quo;
   pss_iu_ctrl_type      iu_ctrl;
   logic [ROOT_W-1:0]    iu_acc;

   pss_iter_unit u_iter (
      .clock (clock),
      .ctrl  (iu_ctrl),
      .acc   (iu_acc)
   );

   assign accept     = req_valid && req_ready;
   assign new_stroke = req_stroke_start || !anchor_valid_ff;
   assign absorbed   = (d2_ff < {1'b0, prod_ff});
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign dx         = {px_ff[COORD_W-1], px_ff} - {ax_ff[COORD_W-1], ax_ff};
   assign dy         = {py_ff[COORD_W-1], py_ff} - {ay_ff[COORD_W-1], ay_ff};
   // a*s*128 + floor(r/2); a*s fits 40 bits
   assign num        = {1'b0, prod_ff[NUM_W-NUM_SHIFT-2:0], {NUM_SHIFT{1'b0}}}
                       + {{(NUM_W-ROOT_W+1){1'b0}}, r_ff[ROOT_W-1:1]};
   assign quo        = iu_acc[COORD_W-1:0];
   assign prod_in    = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = new_stroke ? ST_DONE : ST_DIFF;
         ST_DIFF:      state_in = ST_MUL_X;
         ST_MUL_X:     state_in = ST_MUL_Y;
         ST_MUL_Y:     state_in = ST_MUL_S;
         ST_MUL_S:     state_in = ST_CHECK;
         ST_CHECK: begin
            if (absorbed)               state_in = ST_IDLE;
            else if (strength_ff == '0) state_in = ST_DONE;
            else                        state_in = ST_SQRT_LD;
         end
         ST_SQRT_LD:   state_in = ST_SQRT_RUN;
         ST_SQRT_RUN:  if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = ST_MUL_AX;
         ST_MUL_AX:    state_in = ST_DIV_LD_X;
         ST_DIV_LD_X:  state_in = ST_DIV_RUN_X;
         ST_DIV_RUN_X: if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_UPD_X;
         ST_UPD_X:     state_in = ST_MUL_AY;
         ST_MUL_AY:    state_in = ST_DIV_LD_Y;
         ST_DIV_LD_Y:  state_in = ST_DIV_RUN_Y;
         ST_DIV_RUN_Y: if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_UPD_Y;
         ST_UPD_Y:     state_in = ST_DONE;
         ST_DONE:      if (load_rsp) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake, multiplier operands, root/divide unit
   always_comb begin
      req_ready        = 1'b0;
      mul_a            = '0;
      mul_b            = '0;
      iu_ctrl.op       = IU_HOLD;
      iu_ctrl.load_rem = '0;
      iu_ctrl.load_src = '0;
      iu_ctrl.divisor  = r_ff;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_MUL_X: begin
            mul_a = adx_ff;
            mul_b = adx_ff;
         end
         ST_MUL_Y: begin
            mul_a = ady_ff;
            mul_b = ady_ff;
         end
         ST_MUL_S: begin
            mul_a = {{(COORD_W-STR_W){1'b0}}, strength_ff};
            mul_b = {{(COORD_W-STR_W){1'b0}}, strength_ff};
         end
         ST_SQRT_LD: begin
            iu_ctrl.op       = IU_LOAD;
            iu_ctrl.load_src = {{(RAD_W-D2_W-SQRT_SHIFT){1'b0}}, d2_ff,
                                {SQRT_SHIFT{1'b0}}};
         end
         ST_SQRT_RUN: iu_ctrl.op = IU_STEP_SQRT;
         ST_MUL_AX, ST_MUL_AY: begin
            mul_a = (state_ff == ST_MUL_AX) ? adx_ff : ady_ff;
            mul_b = {{(COORD_W-STR_W){1'b0}}, strength_ff};
         end
         ST_DIV_LD_X, ST_DIV_LD_Y: begin
            // quotient < 2^25, so the top dividend bits already sit below r
            iu_ctrl.op       = IU_LOAD;
            iu_ctrl.load_rem = {{(REM_W-NUM_W+QUO_W){1'b0}}, num[NUM_W-1:QUO_W]};
            iu_ctrl.load_src = {num[QUO_W-1:0], {(RAD_W-QUO_W){1'b0}}};
         end
         ST_DIV_RUN_X, ST_DIV_RUN_Y: iu_ctrl.op = IU_STEP_DIV;
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         anchor_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         strength_ff     <= '0;
         cnt_ff          <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) strength_ff <= csr_wr_data;
         if (accept && new_stroke) anchor_valid_ff <= 1'b1;
         if (load_rsp)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_SQRT_RUN || state_ff == ST_DIV_RUN_X ||
             state_ff == ST_DIV_RUN_Y) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         ay_ff <= '0;
      end else begin
         if (accept && new_stroke) begin
            ax_ff <= req_new_x;
            ay_ff <= req_new_y;
         end
         if (state_ff == ST_CHECK && !absorbed && strength_ff == '0) begin
            ax_ff <= px_ff;
            ay_ff <= py_ff;
         end
         // anchor = point -/+ q, lies between old anchor and point
         if (state_ff == ST_UPD_X) ax_ff <= sx_ff ? px_ff + quo : px_ff - quo;
         if (state_ff == ST_UPD_Y) ay_ff <= sy_ff ? py_ff + quo : py_ff - quo;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         px_ff <= req_new_x;
         py_ff <= req_new_y;
      end
      if (state_ff == ST_DIFF) begin
         sx_ff  <= dx[DIFF_W-1];
         sy_ff  <= dy[DIFF_W-1];
         adx_ff <= dx[DIFF_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
         ady_ff <= dy[DIFF_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      end
      if (state_ff == ST_MUL_Y) d2_ff <= {1'b0, prod_ff};
      if (state_ff == ST_MUL_S) d2_ff <= d2_ff + {1'b0, prod_ff};
      if (state_ff == ST_MUL_AX) r_ff <= iu_acc;
      if (load_rsp) begin
         out_x_ff <= ax_ff;
         out_y_ff <= ay_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;

   // one request at a time
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while busy");

   // a response only appears from the finish state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside finish state");

   // divider never sees a zero root
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN_X || state_ff == ST_DIV_RUN_Y) |-> r_ff != '0)
      else $error("zero divisor");

   // pull never overshoots the old anchor
   a_quo_bound_x: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_X) |-> iu_acc[QUO_W-1:0] <= {1'b0, adx_ff})
      else $error("x pull overshoot");

   a_quo_bound_y: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_Y) |-> iu_acc[QUO_W-1:0] <= {1'b0, ady_ff})
      else $error("y pull overshoot");

endmodule

@@ sv/pss_iter_unit.sv @@
// Shared shift/compare/subtract unit: one root bit or one quotient bit per step.
module pss_iter_unit (
   input  logic                          clock,
   input  pss_pkg::pss_iu_ctrl_type      ctrl,
   output logic [pss_pkg::ROOT_W-1:0]    acc
);
   import pss_pkg::*;

   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] acc_ff,  acc_in;
   logic [RAD_W-1:0]  src_ff,  src_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  opnd;
   logic [REM_W-1:0]  diff;
   logic              ge;
   logic              is_sqrt;

   always_comb begin
      is_sqrt = (ctrl.op == IU_STEP_SQRT);
      if (is_sqrt) begin
         rem_sh = {rem_ff[REM_W-3:0], src_ff[RAD_W-1 -: 2]};
         opnd   = {2'b00, acc_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], src_ff[RAD_W-1]};
         opnd   = {{(REM_W-ROOT_W){1'b0}}, ctrl.divisor};
      end
      ge   = (rem_sh >= opnd);
      diff = rem_sh - opnd;
   end

   always_comb begin
      rem_in = rem_ff;
      acc_in = acc_ff;
      src_in = src_ff;
      unique case (ctrl.op)
         IU_HOLD: begin
         end
         IU_LOAD: begin
            rem_in = ctrl.load_rem;
            acc_in = '0;
            src_in = ctrl.load_src;
         end
         IU_STEP_SQRT: begin
            rem_in = ge ? diff : rem_sh;
            acc_in = {acc_ff[ROOT_W-2:0], ge};
            src_in = {src_ff[RAD_W-3:0], 2'b00};
         end
         IU_STEP_DIV: begin
            rem_in = ge ? diff : rem_sh;
            acc_in = {acc_ff[ROOT_W-2:0], ge};
            src_in = {src_ff[RAD_W-2:0], 1'b0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      src_ff <= src_in;
   end

   assign acc = acc_ff;

endmodule
